[design/ccp_pkg.sv]
// Shared constants, codes and types of the column projection block.
`default_nettype none
package ccp_pkg;

	localparam int NUM_BUCKETS = 4096;
	localparam int SUM_WIDTH   = 32;
	localparam int IDX_W       = $clog2(NUM_BUCKETS);
	localparam int AMT_W       = 17;

	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic REG_RANGE_LEFT = 1'b0;
	localparam logic REG_SIGN_FIX   = 1'b1;

	localparam logic signed [SUM_WIDTH:0] SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH:0] SUM_MIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_READ,
		CMD_READ_NONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [IDX_W-1:0]          idx;
		logic signed [AMT_W-1:0]   amount;
	} cmd_t;

endpackage
`default_nettype wire

[design/ccp_ram.sv]
// Generic single-port-write RAM with registered read.
`default_nettype none
module ccp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[design/ccp_front.sv]
// Front end: config registers, pen tracking, decode of items into bucket commands.
`default_nettype none
module ccp_front
	import ccp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic        [1:0]  operation,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic signed [1:0]  step_dx,
	input  wire logic signed [1:0]  step_dy,
	input  wire logic        [11:0] bucket_index,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic        [15:0] cfg_data,
	output logic                    cmd_push,
	output cmd_t                    cmd
);

	localparam logic signed [17:0] IDX_MAX = 18'(NUM_BUCKETS - 1);

	logic signed [15:0] pen_x_q, pen_y_q, range_left_q;
	logic               sign_fix_q;

	logic signed [16:0] x17, y17, col17, amt17;
	logic signed [17:0] idx18;
	logic [IDX_W-1:0]   idx_clamped;

	always_comb begin
		x17   = 17'(pen_x_q);
		y17   = 17'(pen_y_q);
		if (step_dx > 0) begin
			col17 = x17;
			amt17 = sign_fix_q ? -y17 : y17;
		end else begin
			col17 = x17 - 17'sd1;
			amt17 = sign_fix_q ? y17 : -y17;
		end
		idx18 = 18'(col17) - 18'(range_left_q);
		if (idx18 < 0) begin
			idx_clamped = '0;
		end else if (idx18 > IDX_MAX) begin
			idx_clamped = IDX_W'(NUM_BUCKETS - 1);
		end else begin
			idx_clamped = IDX_W'(idx18);
		end
	end

	always_comb begin
		cmd_push = 1'b0;
		cmd      = '{kind: CMD_ADD, idx: '0, amount: '0};
		unique case (operation)
			OP_STEP: begin
				cmd_push   = accept && (step_dx != 2'sd0);
				cmd.kind   = CMD_ADD;
				cmd.idx    = idx_clamped;
				cmd.amount = amt17;
			end
			OP_READ: begin
				cmd_push = accept;
				if (32'(bucket_index) < NUM_BUCKETS) begin
					cmd.kind = CMD_READ;
				end else begin
					cmd.kind = CMD_READ_NONE;
				end
				cmd.idx = IDX_W'(bucket_index);
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q      <= '0;
			pen_y_q      <= '0;
			range_left_q <= '0;
			sign_fix_q   <= 1'b1;
		end else begin
			if (accept && operation == OP_START) begin
				pen_x_q <= start_x;
				pen_y_q <= start_y;
			end else if (accept && operation == OP_STEP) begin
				pen_x_q <= pen_x_q + 16'(step_dx);
				pen_y_q <= pen_y_q + 16'(step_dy);
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_RANGE_LEFT: range_left_q <= cfg_data;
					REG_SIGN_FIX:   sign_fix_q   <= cfg_data[0];
					default:        range_left_q <= range_left_q;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[design/ccp_cmd_queue.sv]
// Short command queue between front and back end.
`default_nettype none
module ccp_cmd_queue
	import ccp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_cmd,
	input  wire logic rd_en,
	output logic      full,
	output logic      valid,
	output cmd_t      head
);

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_PTR_W:0]   count_q;

	assign full  = (count_q == (CQ_PTR_W+1)'(CQ_DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/ccp_back.sv]
// Back end: clearing pass, bucket read-modify-write and result queue.
`default_nettype none
module ccp_back
	import ccp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	input  wire cmd_t         cmd,
	output logic              cmd_pop,
	output logic              clearing,
	output logic              empty,
	input  wire logic         pop,
	output logic signed [31:0] bucket_value
);

	localparam int EXT_W = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;
	localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'(32'sh7FFF_FFFF);
	localparam logic signed [EXT_W-1:0] OUT_MIN = EXT_W'(32'sh8000_0000);

	// clearing pass
	logic             clr_q;
	logic [IDX_W-1:0] clr_cnt_q;

	// read-modify-write stage
	logic valid_s1;
	cmd_t cmd_s1;

	// bypass of the write made in the previous cycle
	logic                        byp_valid_q;
	logic [IDX_W-1:0]            byp_addr_q;
	logic signed [SUM_WIDTH-1:0] byp_data_q;

	// result queue
	logic signed [31:0]  rq_mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] rq_wr_ptr_q, rq_rd_ptr_q;
	logic [RQ_PTR_W:0]   rq_count_q;

	logic [SUM_WIDTH-1:0]        rdata;
	logic signed [SUM_WIDTH-1:0] old_val;
	logic signed [SUM_WIDTH:0]   sum;
	logic signed [SUM_WIDTH-1:0] sum_sat;
	logic signed [EXT_W-1:0]     old_ext;
	logic signed [31:0]          rd_val;
	logic                        s1_rd, res_push, res_pop;
	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [SUM_WIDTH-1:0]        ram_wdata;

	assign clearing = clr_q;
	assign s1_rd    = valid_s1 && (cmd_s1.kind != CMD_ADD);
	assign cmd_pop  = !clr_q && cmd_valid &&
	                  ((32'(rq_count_q) + 32'(s1_rd)) < RQ_DEPTH);

	ccp_ram #(
		.WIDTH (SUM_WIDTH),
		.DEPTH (NUM_BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cmd.idx),
		.rdata (rdata)
	);

	always_comb begin
		if (byp_valid_q && byp_addr_q == cmd_s1.idx) begin
			old_val = byp_data_q;
		end else begin
			old_val = $signed(rdata);
		end
		sum = (SUM_WIDTH+1)'(old_val) + (SUM_WIDTH+1)'(cmd_s1.amount);
		if (sum > SUM_MAX) begin
			sum_sat = SUM_WIDTH'(SUM_MAX);
		end else if (sum < SUM_MIN) begin
			sum_sat = SUM_WIDTH'(SUM_MIN);
		end else begin
			sum_sat = SUM_WIDTH'(sum);
		end
		old_ext = EXT_W'(old_val);
		if (cmd_s1.kind != CMD_READ) begin
			rd_val = '0;
		end else if (old_ext > OUT_MAX) begin
			rd_val = 32'(OUT_MAX);
		end else if (old_ext < OUT_MIN) begin
			rd_val = 32'(OUT_MIN);
		end else begin
			rd_val = 32'(old_ext);
		end
	end

	always_comb begin
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = valid_s1 && (cmd_s1.kind != CMD_READ_NONE);
			ram_waddr = cmd_s1.idx;
			ram_wdata = (cmd_s1.kind == CMD_ADD) ? sum_sat : '0;
		end
	end

	assign res_push     = s1_rd;
	assign res_pop      = pop && !empty;
	assign empty        = (rq_count_q == '0);
	assign bucket_value = rq_mem_q[rq_rd_ptr_q];

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
		end
		byp_addr_q <= cmd_s1.idx;
		byp_data_q <= (cmd_s1.kind == CMD_ADD) ? sum_sat : '0;
		if (res_push) begin
			rq_mem_q[rq_wr_ptr_q] <= rd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			byp_valid_q <= 1'b0;
			rq_wr_ptr_q <= '0;
			rq_rd_ptr_q <= '0;
			rq_count_q  <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == IDX_W'(NUM_BUCKETS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1    <= cmd_pop;
			byp_valid_q <= valid_s1 && (cmd_s1.kind != CMD_READ_NONE);
			if (res_push) begin
				rq_wr_ptr_q <= rq_wr_ptr_q + 1'b1;
			end
			if (res_pop) begin
				rq_rd_ptr_q <= rq_rd_ptr_q + 1'b1;
			end
			case ({res_push, res_pop})
				2'b10:   rq_count_q <= rq_count_q + 1'b1;
				2'b01:   rq_count_q <= rq_count_q - 1'b1;
				default: rq_count_q <= rq_count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/chain_code_column_projection.sv]
// Top level: column projection profile from chain-coded outline steps.
// Throughput: one request per cycle, sustained, with the result side popping.
// A read's result goes via the command queue and RMW stage to the result queue.
// The bucket update is one read-modify-write per cycle on a single RAM port pair.
// Reset: asynchronous; pen and config return to defaults, then a clearing pass
// zeroes all NUM_BUCKETS (4096) buckets of the RAM while full is held high.
`default_nettype none
module chain_code_column_projection
	import ccp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request side
	input  wire logic               push,
	output logic                    full,
	input  wire logic        [1:0]  operation,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic signed [1:0]  step_dx,
	input  wire logic signed [1:0]  step_dy,
	input  wire logic        [11:0] bucket_index,
	// result side
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      bucket_value,
	// configuration
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic        [15:0] cfg_data
);

	logic accept;
	logic cmd_push, cq_full, cq_valid, cq_pop, clearing;
	cmd_t cmd_in, cq_head;

	// no request taken while the queue is full or the RAM is being cleared
	assign full   = cq_full || clearing;
	assign accept = push && !full;

	// front end: decode, pen update, bucket index clamp
	ccp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.start_x      (start_x),
		.start_y      (start_y),
		.step_dx      (step_dx),
		.step_dy      (step_dy),
		.bucket_index (bucket_index),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	// decouples front from RAM stalls on the result side
	ccp_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.rd_en  (cq_pop),
		.full   (cq_full),
		.valid  (cq_valid),
		.head   (cq_head)
	);

	// back end: RAM read-modify-write with bypass, result queue
	ccp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cq_valid),
		.cmd          (cq_head),
		.cmd_pop      (cq_pop),
		.clearing     (clearing),
		.empty        (empty),
		.pop          (pop),
		.bucket_value (bucket_value)
	);

endmodule
`default_nettype wire

[design/ccp_checker.sv]
// Port-level checks on the column projection block, bound to the top level.
`default_nettype none
module ccp_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               full,
	input wire logic               empty,
	input wire logic               pop,
	input wire logic signed [31:0] bucket_value
);

	// a waiting result stays put until it is taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(bucket_value)))
		else $error("result changed before pop");

	// clearing pass holds off requests right after reset
	a_full_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> full)
		else $error("request side open during clearing pass");

	// no result can exist straight out of reset
	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> empty)
		else $error("result present after reset");

endmodule

bind chain_code_column_projection ccp_checker u_checker (.*);
`default_nettype wire

[tb/chain_code_column_projection_tb.sv]
// Self-checking testbench for the chain-code column projection block.
import ccp_pkg::*;

// Tracks pen, registers and bucket sums; holds bucket values still owed by the block.
class column_profile_scoreboard;
	logic signed [15:0] range_left;
	bit                 fix_mode;
	logic        [15:0] pen_x;
	logic        [15:0] pen_y;
	longint             column_sums [NUM_BUCKETS];
	logic signed [31:0] owed_bucket_values [$];
	int                 errors;

	function new();
		range_left = '0;
		fix_mode   = 1'b1;
		pen_x      = '0;
		pen_y      = '0;
		errors     = 0;
		foreach (column_sums[i]) column_sums[i] = 0;
	endfunction

	function void write_register(logic index, logic [15:0] data);
		if (index == REG_RANGE_LEFT) begin
			range_left = data;
		end else begin
			fix_mode = data[0];
		end
	endfunction

	function longint saturate(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function void add_to_column(longint col, longint amount);
		longint idx;
		idx = col - longint'(range_left);
		if (idx < 0) idx = 0;
		if (idx > NUM_BUCKETS - 1) idx = NUM_BUCKETS - 1;
		column_sums[idx] = saturate(column_sums[idx] + amount, SUM_WIDTH);
	endfunction

	function void note_request(logic [1:0] op, logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [1:0] dx, logic signed [1:0] dy, logic [11:0] bi);
		longint x;
		longint y;
		longint mx;
		longint my;
		longint value;
		x  = longint'($signed(pen_x));
		y  = longint'($signed(pen_y));
		mx = longint'(dx);
		my = longint'(dy);
		case (op)
		OP_START: begin
			pen_x = sx;
			pen_y = sy;
		end
		OP_STEP: begin
			if (mx > 0) begin
				add_to_column(x, fix_mode ? -y : y);
			end else if (mx < 0) begin
				add_to_column(x - 1, fix_mode ? y : -y);
			end
			pen_x = 16'(x + mx);
			pen_y = 16'(y + my);
		end
		OP_READ: begin
			value = 0;
			if (bi < NUM_BUCKETS) begin
				value = column_sums[bi];
				column_sums[bi] = 0;
			end
			owed_bucket_values.push_back(32'(saturate(value, 32)));
		end
		default: ;
		endcase
	endfunction

	function void check_value(logic signed [31:0] got);
		logic signed [31:0] want;
		if (owed_bucket_values.size() == 0) begin
			errors++;
			$display("%0t: bucket_value expected none actual %0d", $time, got);
			return;
		end
		want = owed_bucket_values.pop_front();
		if (got !== want) begin
			errors++;
			$display("%0t: bucket_value expected %0d actual %0d", $time, want, got);
		end
	endfunction

	function int owed();
		return owed_bucket_values.size();
	endfunction
endclass

module chain_code_column_projection_tb;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               push         = 1'b0;
	logic        [1:0]  operation    = '0;
	logic signed [15:0] start_x      = '0;
	logic signed [15:0] start_y      = '0;
	logic signed [1:0]  step_dx      = '0;
	logic signed [1:0]  step_dy      = '0;
	logic        [11:0] bucket_index = '0;
	logic               pop          = 1'b0;
	logic               cfg_write    = 1'b0;
	logic               cfg_index    = 1'b0;
	logic        [15:0] cfg_data     = '0;
	wire                full;
	wire                empty;
	wire signed  [31:0] bucket_value;

	column_profile_scoreboard scb;

	// percentage of cycles in which the sender holds back or the receiver refuses
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	// requests that reach the block's state (the unused code does not count)
	int requests_sent = 0;

	chain_code_column_projection dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.start_x      (start_x),
		.start_y      (start_y),
		.step_dx      (step_dx),
		.step_dy      (step_dy),
		.bucket_index (bucket_index),
		.empty        (empty),
		.pop          (pop),
		.bucket_value (bucket_value),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// Result side: values sampled are those before the edge, so a pop that was high
	// going into this edge with empty low is an accepted result.
	always @(posedge clk) begin
		if (pop === 1'b1 && empty === 1'b0) begin
			scb.check_value(bucket_value);
		end
		pop <= ($urandom_range(0, 99) >= pop_stall_pct);
	end

	// One request: hold it until full is low at an edge, then let the scoreboard see it.
	// push stays high into the next request unless an idle gap is drawn.
	task automatic send_request(logic [1:0] op, logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [1:0] dx, logic signed [1:0] dy, logic [11:0] bi);
		push         <= 1'b1;
		operation    <= op;
		start_x      <= sx;
		start_y      <= sy;
		step_dx      <= dx;
		step_dy      <= dy;
		bucket_index <= bi;
		do @(posedge clk); while (full !== 1'b0);
		scb.note_request(op, sx, sy, dx, dy, bi);
		if (op != OP_UNUSED) requests_sent++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every owed bucket value is back; extra cycles
	// let steps still queued behind the last read pass the read-modify-write.
	task automatic drain();
		push <= 1'b0;
		while (scb.owed() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Both registers back to back; only called with the block idle.
	task automatic set_config(logic signed [15:0] left, bit fix);
		cfg_write <= 1'b1;
		cfg_index <= REG_RANGE_LEFT;
		cfg_data  <= left;
		@(posedge clk);
		scb.write_register(REG_RANGE_LEFT, left);
		cfg_index <= REG_SIGN_FIX;
		cfg_data  <= {15'd0, fix};
		@(posedge clk);
		scb.write_register(REG_SIGN_FIX, {15'd0, fix});
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Well-formed outline: start near bucket zero, a run of steps, then reads of
	// low buckets so that most reads return something accumulated.
	task automatic run_outline();
		logic signed [15:0] base;
		logic        [11:0] idx;
		base = scb.range_left + 16'($urandom_range(0, 24));
		if ($urandom_range(0, 9) == 0) base = 16'($urandom);
		send_request(OP_START, base, 16'($urandom), 2'($urandom), 2'($urandom), 12'($urandom));
		repeat ($urandom_range(2, 12)) begin
			send_request(OP_STEP, 16'($urandom), 16'($urandom), 2'($urandom), 2'($urandom),
				12'($urandom));
		end
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 9))
			0:       idx = 12'($urandom);
			1:       idx = 12'(NUM_BUCKETS - 1);
			default: idx = 12'($urandom_range(0, 32));
			endcase
			send_request(OP_READ, 16'($urandom), 16'($urandom), 2'($urandom), 2'($urandom), idx);
		end
	endtask

	// Random phase: mostly outlines, some lone requests with any code, and now and
	// then a full pause until all owed values are back.
	task automatic run_phase(int count);
		int first;
		first = requests_sent;
		while (requests_sent - first < count) begin
			if ($urandom_range(0, 99) < 3) drain();
			if ($urandom_range(0, 9) == 0) begin
				send_request(2'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
					2'($urandom), 12'($urandom));
			end else begin
				run_outline();
			end
		end
		drain();
	endtask

	initial begin
		logic signed [15:0] lefts [4];
		bit                 fixes [4];
		int                 send_pcts [4];
		int                 stall_pcts [4];
		scb = new();
		lefts      = '{16'sh8000, 16'sd32767, 16'($urandom), 16'($urandom_range(0, 300))};
		fixes      = '{1'b0, 1'b1, 1'b0, 1'b1};
		send_pcts  = '{0, 54, 0, 6};
		stall_pcts = '{0, 0, 54, 6};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its bucket store after reset and holds full high meanwhile
		do @(posedge clk); while (full !== 1'b0);
		set_config(16'sd0, 1'b1);

		// directed: cleared store, both directions, the double move, no horizontal
		// move, clamping at both ends, pen wrap, the unused code
		send_request(OP_READ,   16'sd0,     16'sd0,     2'sd0,  2'sd0,  12'd0);
		send_request(OP_START,  16'sd0,     16'sd100,   2'sd0,  2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sd1,  2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sb11, 2'sd1,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sb10, 2'sb10, 12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sd0,  2'sd1,  12'd0);
		send_request(OP_READ,   16'sd0,     16'sd0,     2'sd0,  2'sd0,  12'd0);
		send_request(OP_START,  16'sd32767, 16'sh8000,  2'sd0,  2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sd1,  2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sb11, 2'sb11, 12'd0);
		send_request(OP_START,  16'sh8000,  16'sd32767, 2'sd0,  2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sd1,  2'sd1,  12'd0);
		send_request(OP_READ,   16'sd0,     16'sd0,     2'sd0,  2'sd0,  12'(NUM_BUCKETS - 1));
		send_request(OP_READ,   16'sd0,     16'sd0,     2'sd0,  2'sd0,  12'd0);
		send_request(OP_UNUSED, 16'shffff,  16'shffff,  2'sb11, 2'sb11, 12'hfff);
		send_request(OP_READ,   16'sd0,     16'sd0,     2'sd0,  2'sd0,  12'(NUM_BUCKETS - 1));
		send_request(OP_START,  16'sd4095,  16'sd1,     2'sd0,  2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sd1,  2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sb11, 2'sd0,  12'd0);
		send_request(OP_STEP,   16'sd0,     16'sd0,     2'sd1,  2'sd0,  12'd0);
		send_request(OP_READ,   16'sd0,     16'sd0,     2'sd0,  2'sd0,  12'(NUM_BUCKETS - 1));
		send_request(OP_READ,   16'sd0,     16'sd0,     2'sd0,  2'sd0,  12'h555);
		drain();

		// random phases, each under its own register setting and idling pattern
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			pop_stall_pct = stall_pcts[p];
			set_config(lefts[p], fixes[p]);
			run_phase(105);
		end

		repeat (10) @(posedge clk);
		if (scb.errors == 0 && scb.owed() == 0) begin
			$display("chain_code_column_projection: match");
		end else begin
			$display("chain_code_column_projection: mismatch");
		end
		$finish;
	end

	// watchdog, well beyond the slowest correct run
	initial begin
		#16_000_000;
		$display("chain_code_column_projection: mismatch");
		$finish;
	end

endmodule
